FILE: hw/rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Types, register indexes and backoff constants shared by the link reconnect
// supervisor and its port checker.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgIdxW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInitialBackoff = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxBackoff     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAttemptTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOfflineRestart = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinUptime      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReportInterval = 3'd5;

  // register reset values
  localparam logic [TimeW-1:0] InitialBackoffRst = 32'd5000;
  localparam logic [TimeW-1:0] MaxBackoffRst     = 32'd60000;
  localparam logic [TimeW-1:0] AttemptTimeoutRst = 32'd20000;
  localparam logic [TimeW-1:0] OfflineRestartRst = 32'd300000;
  localparam logic [TimeW-1:0] MinUptimeRst      = 32'd120000;
  localparam logic [TimeW-1:0] ReportIntervalRst = 32'd60000;

  // backoff ladder steps
  localparam logic [TimeW-1:0] LadderStepA = 32'd15000;
  localparam logic [TimeW-1:0] LadderStepB = 32'd30000;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             disconnect_event;
    logic             address_event;
    logic             link_up;
    logic             abort_raises_event;
  } lrs_in_t;

  typedef struct packed {
    logic             start_attempt;
    logic             abort_attempt;
    logic             restart_request;
    logic             offline_report;
    logic [TimeW-1:0] attempt_total;
  } lrs_out_t;

  // next rung of the backoff ladder, capped at the top
  function automatic logic [TimeW-1:0] ladder_next(input logic [TimeW-1:0] cur,
                                                   input logic [TimeW-1:0] top);
    logic [TimeW-1:0] nxt;
    if (cur < LadderStepA) begin
      nxt = LadderStepA;
    end else if (cur < LadderStepB) begin
      nxt = LadderStepB;
    end else begin
      nxt = top;
    end
    if (nxt > top) begin
      nxt = top;
    end
    return nxt;
  endfunction

endpackage

FILE: hw/rtl/link_reconnect_supervisor.sv
// ----------------------------------------------------------------------------
// link_reconnect_supervisor
// Per-tick reconnect supervision: retry backoff, attempt timeout, offline
// reports and a one-shot restart request.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir | moves
//  in      | in_valid/in_ready/in_data        | in  | one tick request
//  out     | out_valid/out_ready/out_data     | out | one result per tick
//  cfg     | cfg_valid/cfg_ready/cfg_index,   | in  | register write
//          | cfg_data                         |     |
//
// Each tick goes from input to result through an input register, then
// the decision logic that updates state and loads the result register.
// One tick is accepted per cycle while the output side keeps up; a stalled
// result holds the result register and, one tick later, the input register.
// Synchronous active-high reset clears state and reloads register defaults.
// Configuration writes are always accepted (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module link_reconnect_supervisor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lrs_pkg::lrs_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lrs_pkg::lrs_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lrs_pkg::TimeW-1:0]        cfg_data
);

  localparam int unsigned W = lrs_pkg::TimeW;

  // configuration registers
  logic [W-1:0] initial_backoff, max_backoff, attempt_timeout;
  logic [W-1:0] offline_restart, min_uptime, report_interval;

  // supervision state
  logic         attempt_active;
  logic [W-1:0] attempt_started_at;
  logic [W-1:0] next_due_at;
  logic [W-1:0] current_backoff;
  logic [W-1:0] attempt_counter;
  logic         first_connect_pending;
  logic         skip_next_backoff;
  logic [W-1:0] offline_since;
  logic [W-1:0] last_report_at;
  logic         restart_armed;

  logic         attempt_active_next;
  logic [W-1:0] attempt_started_at_next;
  logic [W-1:0] next_due_at_next;
  logic [W-1:0] current_backoff_next;
  logic [W-1:0] attempt_counter_next;
  logic         first_connect_pending_next;
  logic         skip_next_backoff_next;
  logic [W-1:0] offline_since_next;
  logic [W-1:0] last_report_at_next;
  logic         restart_armed_next;

  // pipeline registers
  logic               tick_vld;
  lrs_pkg::lrs_in_t   tick;
  logic               res_vld;
  lrs_pkg::lrs_out_t  res;
  lrs_pkg::lrs_out_t  res_next;
  logic               advance;

  assign advance   = !res_vld || out_ready;
  assign in_ready  = !tick_vld || advance;
  assign out_valid = res_vld;
  assign out_data  = res;
  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_backoff <= lrs_pkg::InitialBackoffRst;
      max_backoff     <= lrs_pkg::MaxBackoffRst;
      attempt_timeout <= lrs_pkg::AttemptTimeoutRst;
      offline_restart <= lrs_pkg::OfflineRestartRst;
      min_uptime      <= lrs_pkg::MinUptimeRst;
      report_interval <= lrs_pkg::ReportIntervalRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrs_pkg::RegInitialBackoff: initial_backoff <= cfg_data;
        lrs_pkg::RegMaxBackoff:     max_backoff     <= cfg_data;
        lrs_pkg::RegAttemptTimeout: attempt_timeout <= cfg_data;
        lrs_pkg::RegOfflineRestart: offline_restart <= cfg_data;
        lrs_pkg::RegMinUptime:      min_uptime      <= cfg_data;
        lrs_pkg::RegReportInterval: report_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= 1'b0;
    end else if (in_ready) begin
      tick_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tick <= in_data;
    end
  end

  // tick decision: events first, then offline handling
  always_comb begin
    logic [W-1:0] offline_ms;
    logic [W-1:0] since_report;
    logic [W-1:0] since_start;
    logic [W-1:0] since_due;
    offline_ms                 = '0;
    since_report               = '0;
    since_start                = '0;
    since_due                  = '0;
    attempt_active_next        = attempt_active;
    attempt_started_at_next    = attempt_started_at;
    next_due_at_next           = next_due_at;
    current_backoff_next       = current_backoff;
    attempt_counter_next       = attempt_counter;
    first_connect_pending_next = first_connect_pending;
    skip_next_backoff_next     = skip_next_backoff;
    offline_since_next         = offline_since;
    last_report_at_next        = last_report_at;
    restart_armed_next         = restart_armed;
    res_next                   = '0;

    // disconnect event
    if (tick.disconnect_event) begin
      attempt_active_next = 1'b0;
      if (offline_since_next == '0) begin
        offline_since_next  = tick.now_ms;
        last_report_at_next = '0;
      end
      if (skip_next_backoff_next) begin
        skip_next_backoff_next = 1'b0;
      end else if (!tick.link_up) begin
        next_due_at_next     = tick.now_ms + current_backoff_next;
        current_backoff_next = lrs_pkg::ladder_next(current_backoff_next, max_backoff);
      end
    end

    // got-address event
    if (tick.address_event) begin
      attempt_active_next        = 1'b0;
      first_connect_pending_next = 1'b0;
      current_backoff_next       = initial_backoff;
      offline_since_next         = '0;
      last_report_at_next        = '0;
      restart_armed_next         = 1'b1;
    end

    // link down: reports, restart, timeout, new attempt
    if (!tick.link_up) begin
      if (offline_since_next == '0) begin
        offline_since_next  = tick.now_ms;
        last_report_at_next = '0;
      end
      offline_ms   = tick.now_ms - offline_since_next;
      since_report = tick.now_ms - last_report_at_next;
      since_start  = tick.now_ms - attempt_started_at_next;
      since_due    = tick.now_ms - next_due_at_next;
      if (offline_ms >= report_interval &&
          (last_report_at_next == '0 || since_report >= report_interval)) begin
        last_report_at_next     = tick.now_ms;
        res_next.offline_report = 1'b1;
      end
      if (restart_armed_next && offline_ms >= offline_restart &&
          tick.now_ms >= min_uptime) begin
        restart_armed_next       = 1'b0;
        res_next.restart_request = 1'b1;
      end else if (attempt_active_next) begin
        if (since_start >= attempt_timeout) begin
          attempt_active_next    = 1'b0;
          skip_next_backoff_next = tick.abort_raises_event;
          next_due_at_next       = tick.now_ms + current_backoff_next;
          current_backoff_next   = lrs_pkg::ladder_next(current_backoff_next, max_backoff);
          res_next.abort_attempt = 1'b1;
        end
      end else if (first_connect_pending_next || !since_due[W-1]) begin
        first_connect_pending_next = 1'b0;
        attempt_counter_next       = attempt_counter_next + W'(1);
        attempt_active_next        = 1'b1;
        attempt_started_at_next    = tick.now_ms;
        res_next.start_attempt     = 1'b1;
      end
    end
    res_next.attempt_total = attempt_counter_next;
  end

  // state and result update
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld               <= 1'b0;
      attempt_active        <= 1'b0;
      attempt_started_at    <= '0;
      next_due_at           <= '0;
      current_backoff       <= lrs_pkg::InitialBackoffRst;
      attempt_counter       <= '0;
      first_connect_pending <= 1'b1;
      skip_next_backoff     <= 1'b0;
      offline_since         <= '0;
      last_report_at        <= '0;
      restart_armed         <= 1'b1;
    end else if (advance) begin
      res_vld <= tick_vld;
      if (tick_vld) begin
        attempt_active        <= attempt_active_next;
        attempt_started_at    <= attempt_started_at_next;
        next_due_at           <= next_due_at_next;
        current_backoff       <= current_backoff_next;
        attempt_counter       <= attempt_counter_next;
        first_connect_pending <= first_connect_pending_next;
        skip_next_backoff     <= skip_next_backoff_next;
        offline_since         <= offline_since_next;
        last_report_at        <= last_report_at_next;
        restart_armed         <= restart_armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_vld) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/lrs_checker.sv
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks for the link reconnect supervisor, bound to its top level.
// ----------------------------------------------------------------------------
module lrs_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input lrs_pkg::lrs_out_t out_data
);

  // a tick never both starts and aborts an attempt
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.start_attempt && out_data.abort_attempt))
    else $error("start and abort in the same result");

  // a restart request ends the tick's attempt handling
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.restart_request) |->
      (!out_data.start_attempt && !out_data.abort_attempt))
    else $error("attempt action alongside restart request");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind link_reconnect_supervisor lrs_checker u_lrs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_reconnect_supervisor testbench
// Drives supervision ticks through the request channel and keeps its own copy
// of the retry, timeout, offline-report and restart logic. Each result is
// compared field by field with the predicted outcome of the matching tick.
// Register phases range from short timers to all-zero and all-ones values.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TimeW      = lrs_pkg::TimeW;
  localparam int unsigned CfgIdxW    = lrs_pkg::CfgIdxW;
  localparam int unsigned NumRegs    = lrs_pkg::NumRegs;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 8;
  localparam logic [CfgIdxW-1:0] RegBeyondLast = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] RegTopIndex   = '1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  lrs_pkg::lrs_in_t in_data;
  logic out_valid;
  logic out_ready;
  lrs_pkg::lrs_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimeW-1:0] cfg_data;

  link_reconnect_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // idle rates in percent
  int unsigned send_gap_pct = 19;
  int unsigned recv_stall_pct = 57;

  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;

  // supervisor state as predicted
  logic [TimeW-1:0] cfg_regs [NumRegs] = '{lrs_pkg::InitialBackoffRst,
                                           lrs_pkg::MaxBackoffRst,
                                           lrs_pkg::AttemptTimeoutRst,
                                           lrs_pkg::OfflineRestartRst,
                                           lrs_pkg::MinUptimeRst,
                                           lrs_pkg::ReportIntervalRst};
  logic             p_active = 1'b0;
  logic [TimeW-1:0] p_started_at = '0;
  logic [TimeW-1:0] p_next_due = '0;
  logic [TimeW-1:0] p_backoff = lrs_pkg::InitialBackoffRst;
  logic [TimeW-1:0] p_attempts = '0;
  logic             p_first_pending = 1'b1;
  logic             p_skip_backoff = 1'b0;
  logic [TimeW-1:0] p_offline_since = '0;
  logic [TimeW-1:0] p_last_report = '0;
  logic             p_restart_armed = 1'b1;

  lrs_pkg::lrs_out_t predicted_outcomes [$];
  lrs_pkg::lrs_out_t last_outcome;
  lrs_pkg::lrs_out_t head_outcome;

  // stimulus-side link picture
  logic [TimeW-1:0] clock_ms = '0;
  logic             link_ok = 1'b0;
  logic             echo_disconnect = 1'b0;

  // next retry time and one rung up the backoff ladder
  function automatic void schedule_retry(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] top;
    logic [TimeW-1:0] rung;
    top = cfg_regs[lrs_pkg::RegMaxBackoff];
    p_next_due = now + p_backoff;
    if (p_backoff < lrs_pkg::LadderStepA) begin
      rung = lrs_pkg::LadderStepA;
    end else if (p_backoff < lrs_pkg::LadderStepB) begin
      rung = lrs_pkg::LadderStepB;
    end else begin
      rung = top;
    end
    p_backoff = (rung > top) ? top : rung;
  endfunction

  // zero means not offline, so a mark at time zero is taken again later
  function automatic void mark_offline(input logic [TimeW-1:0] now);
    if (p_offline_since == '0) begin
      p_offline_since = now;
      p_last_report = '0;
    end
  endfunction

  function automatic lrs_pkg::lrs_out_t supervise_tick(input lrs_pkg::lrs_in_t t);
    lrs_pkg::lrs_out_t r;
    logic [TimeW-1:0] offline_ms;
    logic [TimeW-1:0] since_report;
    logic [TimeW-1:0] since_due;
    logic [TimeW-1:0] running_ms;
    r = '0;
    // link dropped
    if (t.disconnect_event) begin
      p_active = 1'b0;
      mark_offline(t.now_ms);
      if (p_skip_backoff) begin
        p_skip_backoff = 1'b0;
      end else if (!t.link_up) begin
        schedule_retry(t.now_ms);
      end
    end
    // connected: back to the first rung, watchdog re-armed
    if (t.address_event) begin
      p_active = 1'b0;
      p_first_pending = 1'b0;
      p_backoff = cfg_regs[lrs_pkg::RegInitialBackoff];
      p_offline_since = '0;
      p_last_report = '0;
      p_restart_armed = 1'b1;
    end
    // offline handling, only while the link is down
    if (!t.link_up) begin
      mark_offline(t.now_ms);
      offline_ms = t.now_ms - p_offline_since;
      since_report = t.now_ms - p_last_report;
      since_due = t.now_ms - p_next_due;
      running_ms = t.now_ms - p_started_at;
      if (offline_ms >= cfg_regs[lrs_pkg::RegReportInterval] &&
          (p_last_report == '0 ||
           since_report >= cfg_regs[lrs_pkg::RegReportInterval])) begin
        p_last_report = t.now_ms;
        r.offline_report = 1'b1;
      end
      if (p_restart_armed && offline_ms >= cfg_regs[lrs_pkg::RegOfflineRestart] &&
          t.now_ms >= cfg_regs[lrs_pkg::RegMinUptime]) begin
        p_restart_armed = 1'b0;
        r.restart_request = 1'b1;
      end else if (p_active) begin
        if (running_ms >= cfg_regs[lrs_pkg::RegAttemptTimeout]) begin
          p_active = 1'b0;
          p_skip_backoff = t.abort_raises_event;
          schedule_retry(t.now_ms);
          r.abort_attempt = 1'b1;
        end
      end else if (p_first_pending || !since_due[TimeW-1]) begin
        p_first_pending = 1'b0;
        p_attempts = p_attempts + TimeW'(1);
        p_active = 1'b1;
        p_started_at = t.now_ms;
        r.start_attempt = 1'b1;
      end
    end
    r.attempt_total = p_attempts;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [TimeW-1:0] want,
                                        input logic [TimeW-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  // one tick request; valid stays up across back-to-back requests
  task automatic send_tick(input lrs_pkg::lrs_in_t t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    last_outcome = supervise_tick(t);
    predicted_outcomes.push_back(last_outcome);
  endtask

  task automatic tick(input logic [TimeW-1:0] now, input logic disc, input logic addr,
                      input logic up, input logic abr);
    lrs_pkg::lrs_in_t t;
    t.now_ms = now;
    t.disconnect_event = disc;
    t.address_event = addr;
    t.link_up = up;
    t.abort_raises_event = abr;
    send_tick(t);
  endtask

  // hold off new requests until every result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_outcomes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx < NumRegs) begin
      cfg_regs[idx] = val;
    end
    @(posedge clk);
  endtask

  task automatic program_registers(input logic [TimeW-1:0] init_backoff,
                                   input logic [TimeW-1:0] max_backoff,
                                   input logic [TimeW-1:0] timeout,
                                   input logic [TimeW-1:0] restart_after,
                                   input logic [TimeW-1:0] uptime,
                                   input logic [TimeW-1:0] report_every);
    wait_for_results();
    write_reg(lrs_pkg::RegInitialBackoff, init_backoff);
    write_reg(lrs_pkg::RegMaxBackoff, max_backoff);
    write_reg(lrs_pkg::RegAttemptTimeout, timeout);
    write_reg(lrs_pkg::RegOfflineRestart, restart_after);
    write_reg(lrs_pkg::RegMinUptime, uptime);
    write_reg(lrs_pkg::RegReportInterval, report_every);
  endtask

  // link sessions with random timing, some noise ticks, a drain halfway
  task automatic random_ticks(input int count, input int unsigned step_max);
    lrs_pkg::lrs_in_t t;
    int unsigned roll;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_for_results();
      end
      roll = $urandom_range(99);
      // time steps on or jumps (retry due, timeout edge, far, random, zero); other rolls keep the millisecond
      if (roll < 75) begin
        clock_ms = clock_ms + $urandom_range(1, step_max);
      end else if (roll < 79) begin
        clock_ms = p_next_due + $urandom_range(2) - 1;
      end else if (roll < 82) begin
        clock_ms = p_started_at + cfg_regs[lrs_pkg::RegAttemptTimeout] +
                   $urandom_range(2) - 1;
      end else if (roll < 86) begin
        clock_ms = clock_ms + $urandom_range(32'h7fff_fff0, 32'h8000_0010);
      end else if (roll < 91) begin
        clock_ms = $urandom;
      end else if (roll < 92) begin
        clock_ms = '0;
      end
      t = '0;
      t.now_ms = clock_ms;
      // link changes carry their event most of the time
      if ($urandom_range(99) < 7) begin
        link_ok = !link_ok;
        if (link_ok) begin
          t.address_event = ($urandom_range(9) != 0);
        end else begin
          t.disconnect_event = ($urandom_range(9) != 0);
        end
      end else if (echo_disconnect) begin
        t.disconnect_event = 1'b1;
      end
      t.link_up = link_ok;
      t.abort_raises_event = 1'($urandom_range(1));
      if ($urandom_range(99) < 8) begin
        {t.disconnect_event, t.address_event, t.link_up} = 3'($urandom_range(7));
      end
      send_tick(t);
      echo_disconnect = last_outcome.abort_attempt && t.abort_raises_event;
    end
  endtask

  task automatic test_directed_ticks();
    tick(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    tick(32'd25000, 1'b0, 1'b0, 1'b0, 1'b1);
    tick(32'd25000, 1'b1, 1'b0, 1'b0, 1'b0);
    tick(32'd29999, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd30000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd50000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd65000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd90000, 1'b0, 1'b1, 1'b1, 1'b0);
    tick(32'd95000, 1'b1, 1'b0, 1'b1, 1'b0);
    tick(32'd100000, 1'b1, 1'b0, 1'b0, 1'b0);
    tick(32'd160000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd170000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd395000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd396000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd700000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'd700000, 1'b1, 1'b1, 1'b0, 1'b1);
    tick(32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b1);
    tick(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
    tick(32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1);
    clock_ms = 32'hffff_ffff;
  endtask

  task automatic test_default_registers();
    random_ticks(250, 40000);
  endtask

  task automatic test_short_timers();
    program_registers($urandom_range(0, 20000), $urandom_range(0, 70000),
                      $urandom_range(1, 30000), $urandom_range(1000, 200000),
                      $urandom_range(0, 200000), $urandom_range(100, 60000));
    random_ticks(250, 8000);
  endtask

  task automatic test_zero_registers();
    program_registers('0, '0, '0, '0, '0, '0);
    // writes past the last register are dropped
    write_reg(RegBeyondLast, $urandom);
    write_reg(RegTopIndex, $urandom);
    random_ticks(200, 50);
  endtask

  task automatic test_saturated_registers();
    program_registers('1, '1, '1, '1, '1, '1);
    random_ticks(200, 32'h1000_0000);
  endtask

  task automatic test_random_registers();
    program_registers($urandom_range(1) ? $urandom : '0, $urandom_range(1) ? $urandom : '0,
                      $urandom_range(1) ? $urandom : '0, $urandom_range(1) ? $urandom : '0,
                      $urandom_range(1) ? $urandom : '0, $urandom_range(1) ? $urandom : '0);
    random_ticks(250, 32'h0100_0000);
  endtask

  task automatic test_mixed_timers();
    program_registers(lrs_pkg::InitialBackoffRst, lrs_pkg::MaxBackoffRst,
                      lrs_pkg::AttemptTimeoutRst, lrs_pkg::OfflineRestartRst,
                      lrs_pkg::MinUptimeRst, lrs_pkg::ReportIntervalRst);
    random_ticks(350, 30000);
  endtask

  // result checking against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (predicted_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result with nothing predicted: %p", out_data);
          end
        end else begin
          head_outcome = predicted_outcomes.pop_front();
          compare_field("start_attempt", TimeW'(head_outcome.start_attempt),
                        TimeW'(out_data.start_attempt));
          compare_field("abort_attempt", TimeW'(head_outcome.abort_attempt),
                        TimeW'(out_data.abort_attempt));
          compare_field("restart_request", TimeW'(head_outcome.restart_request),
                        TimeW'(out_data.restart_request));
          compare_field("offline_report", TimeW'(head_outcome.offline_report),
                        TimeW'(out_data.offline_report));
          compare_field("attempt_total", head_outcome.attempt_total, out_data.attempt_total);
        end
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 19;
    recv_stall_pct = 57;
    test_directed_ticks();
    test_default_registers();
    test_short_timers();

    send_gap_pct = 57;
    recv_stall_pct = 19;
    test_zero_registers();
    test_saturated_registers();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_registers();
    test_mixed_timers();

    wait_for_results();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
